@@ design/blca_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blca_pkg
// Shared types and constants of the binary-lifting ancestor engine.
// ----------------------------------------------------------------------------
package blca_pkg;

   localparam int NODE_W         = 10;
   localparam int DEPTH_W        = 10;
   localparam int JUMP_BITS      = 10;
   localparam int CNT_W          = 11;
   localparam int BT_W           = $clog2(JUMP_BITS + 1);
   localparam int DEF_MAX_NODES  = 1024;
   localparam int DEF_LOG_LEVELS = 10;
   localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1024);

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_LCA   = 2'd2,
      CMD_KTH   = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_BLD_CHECK,
      S_BLD_RD1,
      S_BLD_RD2,
      S_BLD_WR,
      S_CL_SCAN,
      S_CL_RD,
      S_CL_WB,
      S_LCA_DA,
      S_LCA_DB,
      S_LCA_SWAP,
      S_LCA_EQ,
      S_LCA_RU,
      S_LCA_RV,
      S_LCA_CMP
   } state_type;

   // The final read of the common ancestor query gets its own pair of states.
   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_FIN,
      TAIL_RES
   } tail_type;

   typedef enum logic [2:0] {
      RD_BLD_J,
      RD_BLD_CHAIN,
      RD_CLIMB,
      RD_LCA_U,
      RD_LCA_V,
      RD_BASE_U
   } rd_sel_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_U,
      RES_V,
      RES_RD
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      logic        capture_kth;
      logic        load_wr;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        bld_wr;
      logic        lvl_set_one;
      logic        lvl_set_top;
      logic        lvl_inc;
      logic        lvl_dec;
      logic        j_clr;
      logic        j_inc;
      logic        bt_inc;
      logic        reps_load;
      logic        reps_dec;
      logic        v_from_rd;
      logic        dep_rd;
      logic        dep_sel_v;
      logic        du_load;
      logic        swap;
      logic        au_load;
      logic        lca_cmp;
      logic        res_load;
      res_sel_type res_sel;
   } ctl_cmd_type;

   typedef struct packed {
      logic bld_empty;
      logic j_last;
      logic lvl_last;
      logic lvl_zero;
      logic bt_end;
      logic k_bit;
      logic reps_last;
      logic same_node;
   } dp_status_type;

endpackage

@@ design/blca_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blca_ctrl
// Sequencer for load, build, k-th ancestor and common ancestor commands.
// ----------------------------------------------------------------------------
module blca_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_cmd,
   input  blca_pkg::dp_status_type st,
   output blca_pkg::ctl_cmd_type  ctl,
   output logic                   busy,
   output logic                   rsp_valid,
   output logic                   rsp_result_kind
);
   import blca_pkg::*;

   state_type state_ff, state_in;
   tail_type  tail_ff, tail_in;
   logic      is_lca_ff, is_lca_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_kind_ff, rsp_kind_in;
   logic      accept;
   logic      finish;
   logic      kind_query;
   cmd_type   cmd;

   assign cmd    = cmd_type'(req_cmd);
   assign busy   = (state_ff != S_IDLE) || (tail_ff != TAIL_NONE);
   assign accept = start && !busy;

   // next state
   always_comb begin
      state_in  = state_ff;
      tail_in   = tail_ff;
      is_lca_in = is_lca_ff;
      unique case (tail_ff)
         TAIL_FIN: tail_in = TAIL_RES;
         TAIL_RES: tail_in = TAIL_NONE;
         default:  tail_in = TAIL_NONE;
      endcase
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               is_lca_in = (cmd == CMD_LCA);
               unique case (cmd)
                  CMD_LOAD:  state_in = S_LOAD;
                  CMD_BUILD: state_in = S_BLD_CHECK;
                  CMD_LCA:   state_in = S_LCA_DA;
                  default:   state_in = S_CL_SCAN;
               endcase
            end
         end
         S_LOAD: state_in = S_IDLE;
         S_BLD_CHECK: state_in = st.bld_empty ? S_IDLE : S_BLD_RD1;
         S_BLD_RD1: state_in = S_BLD_RD2;
         S_BLD_RD2: state_in = S_BLD_WR;
         S_BLD_WR: begin
            if (st.j_last && st.lvl_last) state_in = S_IDLE;
            else state_in = S_BLD_RD1;
         end
         S_CL_SCAN: begin
            if (st.bt_end) state_in = is_lca_ff ? S_LCA_EQ : S_IDLE;
            else if (st.k_bit) state_in = S_CL_RD;
         end
         S_CL_RD: state_in = S_CL_WB;
         S_CL_WB: state_in = st.reps_last ? S_CL_SCAN : S_CL_RD;
         S_LCA_DA: state_in = S_LCA_DB;
         S_LCA_DB: state_in = S_LCA_SWAP;
         S_LCA_SWAP: state_in = S_CL_SCAN;
         S_LCA_EQ: state_in = st.same_node ? S_IDLE : S_LCA_RU;
         S_LCA_RU: state_in = S_LCA_RV;
         S_LCA_RV: state_in = S_LCA_CMP;
         S_LCA_CMP: begin
            if (st.lvl_zero) begin
               state_in = S_IDLE;
               tail_in  = TAIL_FIN;
            end else begin
               state_in = S_LCA_RU;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      ctl        = '0;
      finish     = 1'b0;
      kind_query = 1'b0;
      unique case (tail_ff)
         TAIL_FIN: begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = RD_BASE_U;
         end
         TAIL_RES: begin
            finish      = 1'b1;
            kind_query  = 1'b1;
            ctl.res_sel = RES_RD;
         end
         default: ;
      endcase
      unique case (state_ff)
         S_IDLE: begin
            ctl.capture     = accept;
            ctl.capture_kth = (cmd == CMD_KTH);
         end
         S_LOAD: begin
            ctl.load_wr = 1'b1;
            finish      = 1'b1;
            ctl.res_sel = RES_ZERO;
         end
         S_BLD_CHECK: begin
            ctl.lvl_set_one = 1'b1;
            ctl.j_clr       = 1'b1;
            if (st.bld_empty) begin
               finish      = 1'b1;
               ctl.res_sel = RES_ZERO;
            end
         end
         S_BLD_RD1: begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = RD_BLD_J;
         end
         S_BLD_RD2: begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = RD_BLD_CHAIN;
         end
         S_BLD_WR: begin
            ctl.bld_wr = 1'b1;
            if (st.j_last) begin
               if (st.lvl_last) begin
                  finish      = 1'b1;
                  ctl.res_sel = RES_ZERO;
               end else begin
                  ctl.lvl_inc = 1'b1;
                  ctl.j_clr   = 1'b1;
               end
            end else begin
               ctl.j_inc = 1'b1;
            end
         end
         S_CL_SCAN: begin
            if (st.bt_end) begin
               if (!is_lca_ff) begin
                  finish      = 1'b1;
                  kind_query  = 1'b1;
                  ctl.res_sel = RES_V;
               end
            end else if (st.k_bit) begin
               ctl.reps_load = 1'b1;
            end else begin
               ctl.bt_inc = 1'b1;
            end
         end
         S_CL_RD: begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = RD_CLIMB;
         end
         S_CL_WB: begin
            ctl.v_from_rd = 1'b1;
            ctl.reps_dec  = 1'b1;
            ctl.bt_inc    = st.reps_last;
         end
         S_LCA_DA: ctl.dep_rd = 1'b1;
         S_LCA_DB: begin
            ctl.du_load   = 1'b1;
            ctl.dep_rd    = 1'b1;
            ctl.dep_sel_v = 1'b1;
         end
         S_LCA_SWAP: ctl.swap = 1'b1;
         S_LCA_EQ: begin
            if (st.same_node) begin
               finish      = 1'b1;
               kind_query  = 1'b1;
               ctl.res_sel = RES_U;
            end else begin
               ctl.lvl_set_top = 1'b1;
            end
         end
         S_LCA_RU: begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = RD_LCA_U;
         end
         S_LCA_RV: begin
            ctl.rd_en   = 1'b1;
            ctl.rd_sel  = RD_LCA_V;
            ctl.au_load = 1'b1;
         end
         S_LCA_CMP: begin
            ctl.lca_cmp = 1'b1;
            ctl.lvl_dec = !st.lvl_zero;
         end
         default: ;
      endcase
      ctl.res_load = finish;
   end

   assign rsp_valid_in = finish;
   assign rsp_kind_in  = kind_query;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tail_ff      <= TAIL_NONE;
         is_lca_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_kind_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tail_ff      <= tail_in;
         is_lca_ff    <= is_lca_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_kind_ff  <= rsp_kind_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;

endmodule

@@ design/blca_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blca_dpath
// Ancestor and depth memories, working registers, counters and result.
// ----------------------------------------------------------------------------
module blca_dpath #(
   parameter int MAX_NODES  = blca_pkg::DEF_MAX_NODES,
   parameter int LOG_LEVELS = blca_pkg::DEF_LOG_LEVELS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  blca_pkg::ctl_cmd_type         ctl,
   output blca_pkg::dp_status_type       st,
   input  logic [blca_pkg::NODE_W-1:0]   req_node_a,
   input  logic [blca_pkg::NODE_W-1:0]   req_node_b,
   input  logic [blca_pkg::DEPTH_W-1:0]  req_node_depth,
   input  logic [blca_pkg::JUMP_BITS-1:0] req_jump_count,
   input  logic                          csr_we,
   input  logic [blca_pkg::CNT_W-1:0]    csr_wdata,
   output logic [blca_pkg::NODE_W-1:0]   rsp_result_node
);
   import blca_pkg::*;

   localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int LVL_W     = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
   localparam int ANC_DEPTH = LOG_LEVELS * MAX_NODES;
   localparam int ADDR_W    = $clog2(ANC_DEPTH);

   logic [NODE_W-1:0]  anc_mem [ANC_DEPTH];
   logic [DEPTH_W-1:0] dep_mem [MAX_NODES];

   logic [NODE_W-1:0]    anc_rd_ff;
   logic [DEPTH_W-1:0]   dep_rd_ff;
   logic [NODE_W-1:0]    u_ff, v_ff, au_ff;
   logic [DEPTH_W-1:0]   d_ff, du_ff;
   logic [JUMP_BITS-1:0] k_ff, reps_ff;
   logic [BT_W-1:0]      bt_ff;
   logic [LVL_W-1:0]     lvl_ff;
   logic [IDX_W-1:0]     j_ff;
   logic [CNT_W-1:0]     node_count_ff;
   logic [NODE_W-1:0]    res_ff;

   logic [IDX_W:0]       cnt;
   logic [LVL_W-1:0]     lvl_m1;
   logic [LVL_W-1:0]     cl_level;
   logic [BT_W-1:0]      cl_shift;
   logic [JUMP_BITS-1:0] k_shift;
   logic [ADDR_W-1:0]    raddr, waddr;
   logic [NODE_W-1:0]    wdata;
   logic                 anc_we;
   logic                 a_ok;
   logic [IDX_W-1:0]     u_idx, v_idx;

   function automatic logic [IDX_W-1:0] clamp_idx(input logic [NODE_W-1:0] n);
      if (32'(n) < MAX_NODES) return IDX_W'(n);
      return IDX_W'(MAX_NODES - 1);
   endfunction

   function automatic logic [ADDR_W-1:0] anc_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [IDX_W-1:0] idx);
      return ADDR_W'(32'(lvl) * MAX_NODES + 32'(idx));
   endfunction

   assign u_idx  = clamp_idx(u_ff);
   assign v_idx  = clamp_idx(v_ff);
   assign a_ok   = 32'(u_ff) < MAX_NODES;
   assign lvl_m1 = LVL_W'(lvl_ff - 1'b1);
   assign cnt    = (32'(node_count_ff) < MAX_NODES) ? (IDX_W + 1)'(node_count_ff)
                                                    : (IDX_W + 1)'(MAX_NODES);

   // jump bits above the top level repeat the top level
   assign cl_level = (32'(bt_ff) < LOG_LEVELS) ? LVL_W'(bt_ff) : LVL_W'(LOG_LEVELS - 1);
   assign cl_shift = BT_W'(32'(bt_ff) - 32'(cl_level));
   assign k_shift  = k_ff >> bt_ff;

   always_comb begin
      case (ctl.rd_sel)
         RD_BLD_J:     raddr = anc_addr(lvl_m1, j_ff);
         RD_BLD_CHAIN: raddr = anc_addr(lvl_m1, clamp_idx(anc_rd_ff));
         RD_CLIMB:     raddr = anc_addr(cl_level, v_idx);
         RD_LCA_U:     raddr = anc_addr(lvl_ff, u_idx);
         RD_LCA_V:     raddr = anc_addr(lvl_ff, v_idx);
         default:      raddr = anc_addr(LVL_W'(0), u_idx);
      endcase
   end

   assign anc_we = (ctl.load_wr && a_ok) || ctl.bld_wr;
   assign waddr  = ctl.bld_wr ? anc_addr(lvl_ff, j_ff) : anc_addr(LVL_W'(0), u_idx);
   assign wdata  = ctl.bld_wr ? anc_rd_ff : v_ff;

   always_ff @(posedge clock) begin
      if (anc_we) anc_mem[waddr] <= wdata;
      if (ctl.rd_en) anc_rd_ff <= anc_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_wr && a_ok) dep_mem[u_idx] <= d_ff;
      if (ctl.dep_rd) dep_rd_ff <= dep_mem[ctl.dep_sel_v ? v_idx : u_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CNT_RESET;
      end else if (csr_we) begin
         node_count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         u_ff  <= req_node_a;
         v_ff  <= ctl.capture_kth ? req_node_a : req_node_b;
         d_ff  <= req_node_depth;
         k_ff  <= req_jump_count;
         bt_ff <= '0;
      end else begin
         if (ctl.swap) begin
            // keep the shallower node in u and climb v by the depth gap
            if (du_ff > dep_rd_ff) begin
               u_ff <= v_ff;
               v_ff <= u_ff;
               k_ff <= JUMP_BITS'(du_ff - dep_rd_ff);
            end else begin
               k_ff <= JUMP_BITS'(dep_rd_ff - du_ff);
            end
         end
         if (ctl.v_from_rd) v_ff <= anc_rd_ff;
         if (ctl.lca_cmp && (au_ff != anc_rd_ff)) begin
            u_ff <= au_ff;
            v_ff <= anc_rd_ff;
         end
         if (ctl.bt_inc) bt_ff <= BT_W'(bt_ff + 1'b1);
      end
      if (ctl.du_load) du_ff <= dep_rd_ff;
      if (ctl.au_load) au_ff <= anc_rd_ff;
      if (ctl.reps_load) reps_ff <= JUMP_BITS'(1) << cl_shift;
      else if (ctl.reps_dec) reps_ff <= JUMP_BITS'(reps_ff - 1'b1);
      if (ctl.lvl_set_one) lvl_ff <= LVL_W'(1);
      else if (ctl.lvl_set_top) lvl_ff <= LVL_W'(LOG_LEVELS - 1);
      else if (ctl.lvl_inc) lvl_ff <= LVL_W'(lvl_ff + 1'b1);
      else if (ctl.lvl_dec) lvl_ff <= lvl_m1;
      if (ctl.j_clr) j_ff <= '0;
      else if (ctl.j_inc) j_ff <= IDX_W'(j_ff + 1'b1);
      if (ctl.res_load) begin
         case (ctl.res_sel)
            RES_U:   res_ff <= u_ff;
            RES_V:   res_ff <= v_ff;
            RES_RD:  res_ff <= anc_rd_ff;
            default: res_ff <= '0;
         endcase
      end
   end

   assign st.bld_empty = (cnt == '0) || (LOG_LEVELS == 1);
   assign st.j_last    = (32'(j_ff) + 32'd1) == 32'(cnt);
   assign st.lvl_last  = 32'(lvl_ff) == (LOG_LEVELS - 1);
   assign st.lvl_zero  = lvl_ff == '0;
   assign st.bt_end    = 32'(bt_ff) == JUMP_BITS;
   assign st.k_bit     = k_shift[0];
   assign st.reps_last = reps_ff == JUMP_BITS'(1);
   assign st.same_node = u_idx == v_idx;

   assign rsp_result_node = res_ff;

endmodule

@@ design/binary_lifting_lca.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_lifting_lca
// Binary-lifting ancestor engine: node load, doubling-table build,
// k-th ancestor and lowest common ancestor queries.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start & !busy        req_cmd, req_node_a, req_node_b,
//                                 req_node_depth, req_jump_count
//  response  rsp_valid (1 cycle)  rsp_result_node, rsp_result_kind
//  csr       csr_we               csr_wdata (node_count)
//
//  Load: S_LOAD writes the node, then the strobe. Build: after the empty check,
//  each of (LOG_LEVELS-1) * min(node_count, MAX_NODES) entries takes two reads
//  and a write. K-th ancestor: a scan over the jump bits; each set bit climbs
//  v by table reads. LCA reads both depths, swaps, climbs, checks equality,
//  reads both nodes and compares per level, and ends with the final read; it
//  stops at the check when the climbed node already matches. The ancestor
//  memory has a single read port. Reset is synchronous and needs no clearing
//  pass; tables are undefined until loaded. One item at a time; the receiver
//  cannot stall the response.
// ----------------------------------------------------------------------------
module binary_lifting_lca #(
   parameter int MAX_NODES  = blca_pkg::DEF_MAX_NODES,
   parameter int LOG_LEVELS = blca_pkg::DEF_LOG_LEVELS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_cmd,
   input  logic [blca_pkg::NODE_W-1:0]    req_node_a,
   input  logic [blca_pkg::NODE_W-1:0]    req_node_b,
   input  logic [blca_pkg::DEPTH_W-1:0]   req_node_depth,
   input  logic [blca_pkg::JUMP_BITS-1:0] req_jump_count,
   output logic                           rsp_valid,
   output logic [blca_pkg::NODE_W-1:0]    rsp_result_node,
   output logic                           rsp_result_kind,
   input  logic                           csr_we,
   input  logic [blca_pkg::CNT_W-1:0]     csr_wdata
);
   import blca_pkg::*;

   ctl_cmd_type   ctl;
   dp_status_type st;

   blca_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_cmd         (req_cmd),
      .st              (st),
      .ctl             (ctl),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_result_kind (rsp_result_kind)
   );

   blca_dpath #(
      .MAX_NODES  (MAX_NODES),
      .LOG_LEVELS (LOG_LEVELS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .st              (st),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_node_depth  (req_node_depth),
      .req_jump_count  (req_jump_count),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_result_node (rsp_result_node)
   );

   // a transfer always starts work
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after request transfer");

   // the response is issued on the way back to idle
   a_idle_at_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result_kind) |-> (rsp_result_node == '0))
      else $error("acknowledgement carries a nonzero node");

endmodule
